[sv/ple_pkg.sv]
`timescale 1ns / 1ps

package ple_pkg;

    localparam int DATA_W    = 32;
    localparam int POS_W     = 7;
    localparam int LEN_W     = 7;
    localparam int FUNC_W    = 2;
    localparam int DEPTH_DEF = 64;
    localparam int GRP_SIZE  = 8;

    // s_tdata: position, value, pad ; m_tdata: ok, read_value, found_position, length, pad
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 48;

    localparam logic [FUNC_W-1:0] OP_INSERT = 2'd0;
    localparam logic [FUNC_W-1:0] OP_DELETE = 2'd1;
    localparam logic [FUNC_W-1:0] OP_GET    = 2'd2;
    localparam logic [FUNC_W-1:0] OP_FIND   = 2'd3;

    typedef struct packed {
        logic ins;
        logic del;
        logic get;
        logic find;
    } cell_ctl_t;

endpackage

[sv/ple_cell.sv]
`timescale 1ns / 1ps

module ple_cell #(
    parameter int IDX   = 0,
    parameter int CMP_W = 8
) (
    input  logic                      clk,
    input  ple_pkg::cell_ctl_t        ctl,
    input  logic [CMP_W-1:0]          pos_x,
    input  logic [CMP_W-1:0]          cnt_x,
    input  logic [ple_pkg::DATA_W-1:0] key,
    input  logic [ple_pkg::DATA_W-1:0] left_data,
    input  logic [ple_pkg::DATA_W-1:0] right_data,
    output logic [ple_pkg::DATA_W-1:0] data,
    output logic                      hit
);
    import ple_pkg::*;

    localparam logic [CMP_W-1:0] SLOT  = CMP_W'(IDX + 1);
    localparam logic [CMP_W-1:0] IDX_X = CMP_W'(IDX);

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;
    logic              occupied;

    assign occupied = IDX_X < cnt_x;

    always_comb
    begin
        data_next = data_reg;
        if (ctl.ins)
        begin
            if (pos_x == SLOT)
                data_next = key;
            else if (pos_x <= IDX_X)
                data_next = left_data;
        end
        else if (ctl.del)
        begin
            if (pos_x <= SLOT)
                data_next = right_data;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;
    assign hit  = occupied && ((ctl.get && (pos_x == SLOT)) ||
                               (ctl.find && (data_reg == key)));

endmodule

[sv/ple_scan.sv]
`timescale 1ns / 1ps

module ple_scan #(
    parameter int DEPTH = ple_pkg::DEPTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 load,
    input  logic                                 shift,
    input  logic [DEPTH-1:0]                     hit,
    input  logic [DEPTH-1:0][ple_pkg::DATA_W-1:0] data,
    output logic                                 done,
    output logic                                 any_hit,
    output logic [$clog2(DEPTH+1)-1:0]           hit_pos,
    output logic [ple_pkg::DATA_W-1:0]           hit_data
);
    import ple_pkg::*;

    localparam int GROUPS = (DEPTH + GRP_SIZE - 1) / GRP_SIZE;
    localparam int GRP_W  = (GROUPS > 1) ? $clog2(GROUPS) : 1;
    localparam int ENC_W  = $clog2(GRP_SIZE);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int PAD    = GROUPS * GRP_SIZE;

    logic [PAD-1:0]                  hit_pad;
    logic [PAD-1:0][DATA_W-1:0]      data_pad;
    logic [GROUPS-1:0][GRP_SIZE-1:0] grp_hit;
    logic [GROUPS-1:0][DATA_W-1:0]   grp_data;

    logic [GROUPS-1:0][GRP_SIZE-1:0] hit_sr_reg;
    logic [GROUPS-1:0][DATA_W-1:0]   dat_sr_reg;
    logic [GRP_W-1:0]                grp_reg;
    logic [ENC_W-1:0]                enc;
    logic                            last_grp;

    genvar n;
    generate
        for (n = 0; n < PAD; n++)
        begin : g_pad
            if (n < DEPTH)
            begin : g_live
                assign hit_pad[n]  = hit[n];
                assign data_pad[n] = data[n];
            end
            else
            begin : g_zero
                assign hit_pad[n]  = 1'b0;
                assign data_pad[n] = '0;
            end
        end
    endgenerate

    // per group of eight cells: hit bits and the OR of the hit cells' data
    always_comb
    begin
        for (int g = 0; g < GROUPS; g++)
        begin
            grp_data[g] = '0;
            for (int k = 0; k < GRP_SIZE; k++)
            begin
                grp_hit[g][k] = hit_pad[g*GRP_SIZE + k];
                if (hit_pad[g*GRP_SIZE + k])
                    grp_data[g] = grp_data[g] | data_pad[g*GRP_SIZE + k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            hit_sr_reg <= grp_hit;
            dat_sr_reg <= grp_data;
        end
        else if (shift)
        begin
            for (int g = 0; g < GROUPS - 1; g++)
            begin
                hit_sr_reg[g] <= hit_sr_reg[g+1];
                dat_sr_reg[g] <= dat_sr_reg[g+1];
            end
            hit_sr_reg[GROUPS-1] <= '0;
            dat_sr_reg[GROUPS-1] <= '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            grp_reg <= '0;
        else if (load)
            grp_reg <= '0;
        else if (shift)
            grp_reg <= grp_reg + GRP_W'(1);
    end

    // lowest set bit of the head group
    always_comb
    begin
        enc = '0;
        for (int k = GRP_SIZE - 1; k >= 0; k--)
        begin
            if (hit_sr_reg[0][k])
                enc = ENC_W'(k);
        end
    end

    assign last_grp = (grp_reg == GRP_W'(GROUPS - 1));
    assign any_hit  = |hit_sr_reg[0];
    assign done     = any_hit || last_grp;
    assign hit_pos  = CNT_W'({grp_reg, enc}) + CNT_W'(1);
    assign hit_data = dat_sr_reg[0];

endmodule

[sv/positional_list_engine.sv]
`timescale 1ns / 1ps

// Ordered list of up to DEPTH signed 32-bit values, one cell per entry.
// Request channel s_*: s_tuser carries the operation (insert, delete, get,
// find), s_tdata carries position and value. Result channel m_*: one word
// per request with ok, read_value, found_position and length.
// Insert and delete shift the cells from the given position onward on the
// edge that takes the request; that edge also registers the result word.
// Get and find latch one hit bit per cell, then walk those bits eight cells
// per cycle toward the head until the first hit or the last group. One
// request is in flight at a time; a new one is taken in the cycle its
// predecessor's word leaves or while the output register is empty.
// Reset empties the list and drops any pending word; entry storage is not
// cleared and needs no sweep.
// When m_tready is low a pending result word holds and no new request is taken.
module positional_list_engine #(
    parameter int DEPTH = ple_pkg::DEPTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [ple_pkg::S_TDATA_W-1:0]   s_tdata,   // position[6:0], value[38:7], zero pad
    input  logic [ple_pkg::FUNC_W-1:0]      s_tuser,   // func
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [ple_pkg::M_TDATA_W-1:0]   m_tdata    // ok, read_value, found_position, length, pad
);
    import ple_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    logic [POS_W-1:0]  position;
    logic [DATA_W-1:0] value;
    logic [FUNC_W-1:0] func;
    logic [CMP_W-1:0]  pos_x;
    logic [CMP_W-1:0]  cnt_x;

    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic              busy_reg;
    logic              busy_next;
    logic              find_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic              ok_reg;
    logic              ok_next;
    logic [DATA_W-1:0] rd_reg;
    logic [DATA_W-1:0] rd_next;
    logic [LEN_W-1:0]  fpos_reg;
    logic [LEN_W-1:0]  fpos_next;
    logic [LEN_W-1:0]  len_reg;
    logic [LEN_W-1:0]  len_next;

    logic              acc;
    logic              ins_ok;
    logic              del_ok;
    logic              is_search;
    logic              fin;
    cell_ctl_t         ctl;

    logic [DEPTH-1:0][DATA_W-1:0] cell_data;
    logic [DEPTH-1:0]             cell_hit;

    logic              scan_done;
    logic              scan_hit;
    logic [CNT_W-1:0]  scan_pos;
    logic [DATA_W-1:0] scan_data;

    assign position = s_tdata[POS_W-1:0];
    assign value    = s_tdata[POS_W +: DATA_W];
    assign func     = s_tuser;
    assign pos_x    = CMP_W'(position);
    assign cnt_x    = CMP_W'(cnt_reg);

    assign s_tready  = !busy_reg && (!out_valid_reg || m_tready);
    assign acc       = s_tvalid && s_tready;
    assign is_search = (func == OP_GET) || (func == OP_FIND);

    assign ins_ok = (func == OP_INSERT) && (position != '0) &&
                    (pos_x <= cnt_x + CMP_W'(1)) && (cnt_reg < CNT_W'(DEPTH));
    assign del_ok = (func == OP_DELETE) && (position != '0) && (pos_x <= cnt_x);

    assign ctl.ins  = acc && ins_ok;
    assign ctl.del  = acc && del_ok;
    assign ctl.get  = acc && (func == OP_GET);
    assign ctl.find = acc && (func == OP_FIND);

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            logic [DATA_W-1:0] left_in;
            logic [DATA_W-1:0] right_in;
            if (i == 0)
            begin : g_head
                assign left_in = value;
            end
            else
            begin : g_body
                assign left_in = cell_data[i-1];
            end
            if (i == DEPTH - 1)
            begin : g_tail
                assign right_in = cell_data[i];
            end
            else
            begin : g_next
                assign right_in = cell_data[i+1];
            end

            ple_cell #(
                .IDX   (i),
                .CMP_W (CMP_W)
            ) u_cell (
                .clk        (clk),
                .ctl        (ctl),
                .pos_x      (pos_x),
                .cnt_x      (cnt_x),
                .key        (value),
                .left_data  (left_in),
                .right_data (right_in),
                .data       (cell_data[i]),
                .hit        (cell_hit[i])
            );
        end
    endgenerate

    ple_scan #(
        .DEPTH (DEPTH)
    ) u_scan (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (acc && is_search),
        .shift    (busy_reg && !scan_done),
        .hit      (cell_hit),
        .data     (cell_data),
        .done     (scan_done),
        .any_hit  (scan_hit),
        .hit_pos  (scan_pos),
        .hit_data (scan_data)
    );

    assign fin = busy_reg && scan_done && (!out_valid_reg || m_tready);

    always_comb
    begin
        cnt_next       = cnt_reg;
        busy_next      = busy_reg;
        out_valid_next = out_valid_reg;
        ok_next        = ok_reg;
        rd_next        = rd_reg;
        fpos_next      = fpos_reg;
        len_next       = len_reg;

        if (m_tready)
            out_valid_next = 1'b0;

        if (acc)
        begin
            if (is_search)
            begin
                busy_next = 1'b1;
            end
            else
            begin
                if (ctl.ins)
                    cnt_next = cnt_reg + CNT_W'(1);
                else if (ctl.del)
                    cnt_next = cnt_reg - CNT_W'(1);
                out_valid_next = 1'b1;
                ok_next        = ins_ok || del_ok;
                rd_next        = '0;
                fpos_next      = '0;
                len_next       = LEN_W'(cnt_next);
            end
        end
        else if (fin)
        begin
            busy_next      = 1'b0;
            out_valid_next = 1'b1;
            ok_next        = scan_hit;
            rd_next        = (scan_hit && !find_reg) ? scan_data : '0;
            fpos_next      = (scan_hit && find_reg) ? LEN_W'(scan_pos) : '0;
            len_next       = LEN_W'(cnt_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
            find_reg <= (func == OP_FIND);
        ok_reg   <= ok_next;
        rd_reg   <= rd_next;
        fpos_reg <= fpos_next;
        len_reg  <= len_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, len_reg, fpos_reg, rd_reg, ok_reg};

endmodule

[sv/ple_chk.sv]
`timescale 1ns / 1ps

module ple_chk #(
    parameter int DEPTH = ple_pkg::DEPTH_DEF
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tready,
    input logic [ple_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                          m_tvalid,
    input logic                          m_tready
);
    import ple_pkg::*;

    logic             ok;
    logic [DATA_W-1:0] rd;
    logic [LEN_W-1:0] fpos;
    logic [LEN_W-1:0] len;

    assign ok   = m_tdata[0];
    assign rd   = m_tdata[DATA_W:1];
    assign fpos = m_tdata[DATA_W+LEN_W:DATA_W+1];
    assign len  = m_tdata[DATA_W+2*LEN_W:DATA_W+LEN_W+1];

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word dropped or changed under stall");

    // a get and a find never report in the same word
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !((fpos != '0) && (rd != '0)))
        else $error("read_value and found_position both set");

    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && ((fpos != '0) || (rd != '0)) |-> ok)
        else $error("result data without ok");

    a_found_len: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (DEPTH < 128) |-> (fpos <= len) && (len <= LEN_W'(DEPTH)))
        else $error("found position or length out of range");

    // stalled output blocks intake
    a_no_take: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("request taken while result stalled");

endmodule

bind positional_list_engine ple_chk #(
    .DEPTH (DEPTH)
) u_ple_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);

[verif/ple_checker.sv]
`timescale 1ns / 1ps

module ple_checker #(
    parameter int DEPTH = ple_pkg::DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [ple_pkg::S_TDATA_W-1:0] s_tdata,   // position[6:0], value[38:7], zero pad
    input  logic [ple_pkg::FUNC_W-1:0]    s_tuser,   // func
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [ple_pkg::M_TDATA_W-1:0] m_tdata,   // ok, read_value, found_position, length, pad
    output int                            fail_count,
    output int                            pending,
    output int                            list_len,
    output int                            words_checked
);
    import ple_pkg::*;

    typedef struct packed {
        logic              ok;
        logic [DATA_W-1:0] read_value;
        logic [POS_W-1:0]  found_pos;
        logic [LEN_W-1:0]  length;
    } list_result_t;

    logic [DATA_W-1:0] slots [DEPTH];
    int                n_entries = 0;
    list_result_t      result_q [$];

    task automatic report(input string what, input logic [47:0] got, input logic [47:0] want);
        $display("MISMATCH @%0t: %s got 0x%0h want 0x%0h", $time, what, got, want);
        fail_count++;
    endtask

    // Applies one request to the shadow list and returns the word it should produce.
    function automatic list_result_t apply_request(input logic [FUNC_W-1:0] func,
                                                   input int pos,
                                                   input logic [DATA_W-1:0] val);
        list_result_t r;
        int           i;
        r = '0;
        case (func)
            OP_INSERT:
                if (pos >= 1 && pos <= n_entries + 1 && n_entries < DEPTH)
                begin
                    for (i = n_entries; i >= pos; i--)
                        slots[i] = slots[i-1];
                    slots[pos-1] = val;
                    n_entries++;
                    r.ok = 1'b1;
                end
            OP_DELETE:
                if (pos >= 1 && pos <= n_entries)
                begin
                    for (i = pos - 1; i + 1 < n_entries; i++)
                        slots[i] = slots[i+1];
                    n_entries--;
                    r.ok = 1'b1;
                end
            OP_GET:
                if (pos >= 1 && pos <= n_entries)
                begin
                    r.read_value = slots[pos-1];
                    r.ok = 1'b1;
                end
            default:
                for (i = 0; i < n_entries; i++)
                begin
                    if (slots[i] == val)
                    begin
                        r.found_pos = POS_W'(i + 1);
                        r.ok = 1'b1;
                        break;
                    end
                end
        endcase
        r.length = LEN_W'(n_entries);
        return r;
    endfunction

    always @(posedge clk)
    begin
        list_result_t want;
        if (rst_n)
        begin
            // result side first: a word leaving now belongs to an earlier request
            if (m_tvalid && m_tready)
            begin
                if (result_q.size() == 0)
                    report("result word with no request pending", 48'(m_tdata), '0);
                else
                begin
                    want = result_q.pop_front();
                    if (m_tdata[0] !== want.ok)
                        report("ok", 48'(m_tdata[0]), 48'(want.ok));
                    if (m_tdata[32:1] !== want.read_value)
                        report("read_value", 48'(m_tdata[32:1]), 48'(want.read_value));
                    if (m_tdata[39:33] !== want.found_pos)
                        report("found_position", 48'(m_tdata[39:33]), 48'(want.found_pos));
                    if (m_tdata[46:40] !== want.length)
                        report("length", 48'(m_tdata[46:40]), 48'(want.length));
                    words_checked++;
                end
            end
            if (s_tvalid && s_tready)
                result_q.push_back(apply_request(s_tuser, int'(s_tdata[6:0]), s_tdata[38:7]));
        end
        pending  = result_q.size();
        list_len = n_entries;
    end

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps

module testbench;
    import ple_pkg::*;

    localparam int DEPTH       = DEPTH_DEF;
    localparam int PHASE_WORDS = 200;
    localparam int PHASES      = 8;

    logic                   clk;
    logic                   rst_n    = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata  = '0;
    logic [FUNC_W-1:0]      s_tuser  = OP_INSERT;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;

    int chk_fails;
    int chk_pending;
    int chk_len;
    int chk_words;

    bit                quiet       = 1'b0;
    int                holds_asked = 0;
    int                holds_done  = 0;
    int                sent        = 0;
    int                full_inserts = 0;
    logic [DATA_W-1:0] pool [12];

    positional_list_engine #(.DEPTH(DEPTH)) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    ple_checker #(.DEPTH(DEPTH)) u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .fail_count    (chk_fails),
        .pending       (chk_pending),
        .list_len      (chk_len),
        .words_checked (chk_words)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // mostly short gaps, now and then a long one
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // kind: 0 fill, 1/3 mixed, 2 drain
    function automatic logic [FUNC_W-1:0] pick_func(input int kind);
        int r;
        r = $urandom_range(0, 99);
        if (kind == 0)
            return (r < 70) ? OP_INSERT : (r < 80) ? OP_DELETE : (r < 90) ? OP_GET : OP_FIND;
        if (kind == 2)
            return (r < 15) ? OP_INSERT : (r < 70) ? OP_DELETE : (r < 85) ? OP_GET : OP_FIND;
        return (r < 30) ? OP_INSERT : (r < 55) ? OP_DELETE : (r < 75) ? OP_GET : OP_FIND;
    endfunction

    function automatic int pick_pos(input logic [FUNC_W-1:0] f, input int len);
        int r;
        int hi;
        r  = $urandom_range(0, 99);
        hi = (f == OP_INSERT) ? len + 1 : len;
        if (f == OP_FIND || r < 8)
            return (f == OP_FIND) ? $urandom_range(0, 127) : 0;
        if (r < 16)
            return hi + 1;
        if (r < 24)
            return $urandom_range(0, 127);
        if (r < 30)
            return hi;
        return (hi == 0) ? 1 : $urandom_range(1, hi);
    endfunction

    // values from a small pool so find hits and duplicates show up often
    function automatic logic [DATA_W-1:0] pick_val();
        if ($urandom_range(0, 99) < 60)
            return pool[$urandom_range(0, 11)];
        return $urandom;
    endfunction

    task automatic send_word(input logic [FUNC_W-1:0] f, input int p, input logic [DATA_W-1:0] v);
        int gap;
        gap = quiet ? 0 : idle_len();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        if (f == OP_INSERT && chk_len == DEPTH)
            full_inserts++;
        s_tvalid <= 1'b1;
        s_tuser  <= f;
        s_tdata  <= {1'b0, v, p[6:0]};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
        sent++;
    endtask

    // receiver side: random ready pattern plus one long hold-off on request
    initial
    begin
        int span;
        @(negedge clk);
        forever
        begin
            if (holds_done < holds_asked)
            begin
                holds_done++;
                m_tready <= 1'b0;
                repeat (300) @(negedge clk);
            end
            else if (quiet)
            begin
                m_tready <= 1'b1;
                @(negedge clk);
            end
            else if ($urandom_range(0, 99) < 75)
            begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(negedge clk);
            end
            else
            begin
                span = idle_len();
                m_tready <= 1'b0;
                repeat ((span == 0) ? 1 : span) @(negedge clk);
            end
        end
    end

    initial
    begin
        #10_000_000;
        $display("timeout waiting on the block");
        $display("positional_list_engine regression: fail");
        $finish;
    end

    initial
    begin
        int                ph;
        int                k;
        int                n;
        int                n_directed;
        logic [FUNC_W-1:0] f;
        logic [DATA_W-1:0] v;

        pool[0] = 32'h8000_0000;
        pool[1] = 32'h7FFF_FFFF;
        pool[2] = 32'h0000_0000;
        pool[3] = 32'hFFFF_FFFF;
        pool[4] = 32'h0000_0001;
        for (k = 5; k < 12; k++)
            pool[k] = $urandom;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: empty list, bad positions, head/middle/tail edits, duplicates
        send_word(OP_FIND,   0,   32'h0000_0000);
        send_word(OP_GET,    1,   32'h0);
        send_word(OP_DELETE, 1,   32'h0);
        send_word(OP_INSERT, 0,   32'h0000_0005);
        send_word(OP_INSERT, 2,   32'h0000_0005);
        send_word(OP_INSERT, 1,   32'h7FFF_FFFF);
        send_word(OP_INSERT, 1,   32'h8000_0000);
        send_word(OP_INSERT, 3,   32'hFFFF_FFFF);
        send_word(OP_INSERT, 2,   32'h0000_0000);
        send_word(OP_INSERT, 5,   32'h8000_0000);
        send_word(OP_FIND,   127, 32'h8000_0000);
        send_word(OP_FIND,   3,   32'h1234_5678);
        send_word(OP_GET,    0,   32'h0);
        send_word(OP_GET,    5,   32'h0);
        send_word(OP_GET,    6,   32'h0);
        send_word(OP_GET,    127, 32'hFFFF_FFFF);
        send_word(OP_DELETE, 127, 32'h0);
        send_word(OP_DELETE, 0,   32'h0);
        send_word(OP_DELETE, 1,   32'h0);
        send_word(OP_FIND,   0,   32'h8000_0000);
        send_word(OP_DELETE, 4,   32'h0);
        send_word(OP_DELETE, 2,   32'h0);
        send_word(OP_GET,    1,   32'h0);
        send_word(OP_INSERT, 7,   32'h5555_AAAA);
        send_word(OP_DELETE, 2,   32'h0);
        send_word(OP_DELETE, 1,   32'h0);
        n_directed = sent;

        for (ph = 0; ph < PHASES; ph++)
        begin
            quiet = (ph == 5);
            if (ph == 1)
                holds_asked++;
            for (k = 0; k < PHASE_WORDS; k++)
            begin
                f = pick_func(ph % 4);
                v = (f == OP_INSERT || f == OP_FIND) ? pick_val() : $urandom;
                send_word(f, pick_pos(f, chk_len), v);
            end
        end
        quiet = 1'b0;

        s_tvalid <= 1'b0;
        for (n = 0; n < 5000 && chk_pending != 0; n++)
            @(negedge clk);
        repeat (20) @(negedge clk);

        $display("sent %0d requests (%0d directed), checked %0d result words",
                 sent, n_directed, chk_words);
        $display("inserts offered to a full list: %0d; mismatches: %0d", full_inserts, chk_fails);
        if (chk_fails == 0 && chk_pending == 0)
            $display("positional_list_engine regression: pass");
        else
        begin
            if (chk_pending != 0)
                $display("%0d result words never arrived", chk_pending);
            $display("positional_list_engine regression: fail");
        end
        $finish;
    end

endmodule
